/* rtl/sit_pkg.sv */
// sit_pkg: shared types and codes for the sorted insertion table
// command and result codes, control struct, state enum, default sizes
// no dependencies
package sit_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int CMD_W   = 2;
  localparam int KIND_W  = 2;
  localparam int FIELD_W = 32;  // width of the value fields on the ports

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DUMP   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DUMP   = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic ins;  // place the new value, shift larger ones right
    logic rot;  // rotate the valid cells one step toward the head
  } cell_ctrl_t;

endpackage

/* rtl/sorted_insertion_table_core.sv */
// sorted_insertion_table_core: bounded ascending table of signed values in a cell chain
// insert and clear: one per cycle unless m_tready stalls, result valid in the cycle after the accept
// dump: one result per cycle unless m_tready stalls, from the head cell as the chain rotates
// a dump moves to ST_DUMP on its accept and holds the input until all count entries are out
// an empty dump returns its marker in the cycle after its accept; a result waiting on m_tready holds the input
// reset (rst, synchronous) empties the table and drops any pending result; cells are not cleared
module sorted_insertion_table_core #(
  parameter int TABLE_DEPTH = sit_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = sit_pkg::VALUE_WIDTH_DEF,
  localparam int POS_W  = $clog2(TABLE_DEPTH),
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1),
  localparam int OUT_W  = sit_pkg::FIELD_W + POS_W + CNT_W + 2,
  localparam int OUT_BW = ((OUT_W + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst,
  // input transactions
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [sit_pkg::FIELD_W-1:0] s_tdata,  // value
  input  logic [sit_pkg::CMD_W-1:0]   s_tuser,  // command
  // result transactions
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // entry_value, position, entry_count, rejected_full, entry_present, zero fill
  output logic [OUT_BW-1:0]           m_tdata,
  output logic [sit_pkg::KIND_W-1:0]  m_tuser,  // kind
  output logic                        m_tlast
);
  import sit_pkg::*;

  // control state
  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [POS_W-1:0]   idx, idx_next;

  // output register
  logic               o_valid, o_valid_next;
  kind_t              o_kind, o_kind_next;
  logic [FIELD_W-1:0] o_value, o_value_next;
  logic [POS_W-1:0]   o_pos, o_pos_next;
  logic [CNT_W-1:0]   o_count, o_count_next;
  logic               o_rej, o_rej_next;
  logic               o_pres, o_pres_next;
  logic               o_last, o_last_next;

  logic                   out_free;
  logic                   in_accept;
  cmd_t                   cmd;
  logic                   full;
  cell_ctrl_t             ctrl;
  logic [VALUE_WIDTH-1:0] ins_value;

  logic [TABLE_DEPTH-1:0] gt;
  logic [VALUE_WIDTH-1:0] cell_value [TABLE_DEPTH];
  logic [POS_W-1:0]       ins_pos;

  assign out_free  = !o_valid || m_tready;
  assign s_tready  = (state == ST_IDLE) && out_free;
  assign in_accept = s_tvalid && s_tready;
  assign cmd       = cmd_t'(s_tuser);
  assign full      = (count == CNT_W'(TABLE_DEPTH));
  // sign extend the port field to the stored width
  assign ins_value = VALUE_WIDTH'($signed(s_tdata));

  assign ctrl.ins = in_accept && (cmd == CMD_INSERT) && !full;
  assign ctrl.rot = (state == ST_DUMP) && out_free;

  // the chain of cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic                   left_gt;
    logic [VALUE_WIDTH-1:0] left_value;
    logic [VALUE_WIDTH-1:0] right_value;

    if (i == 0) begin : g_head
      assign left_gt    = 1'b0;
      assign left_value = ins_value;
    end else begin : g_body
      assign left_gt    = gt[i-1];
      assign left_value = cell_value[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_end
      assign right_value = cell_value[0];
    end else begin : g_mid
      assign right_value = cell_value[i+1];
    end

    sit_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid      (CNT_W'(i) < count),
      .is_tail    (CNT_W'(i + 1) == count),
      .ins_value  (ins_value),
      .left_gt    (left_gt),
      .left_value (left_value),
      .right_value(right_value),
      .head_value (cell_value[0]),
      .gt         (gt[i]),
      .value      (cell_value[i])
    );
  end

  // insert position: index of the single cell where gt switches on
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (gt[i] && (i == 0 || !gt[(i == 0) ? 0 : i - 1])) begin
        ins_pos = ins_pos | POS_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      idx     <= '0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      idx     <= idx_next;
      o_valid <= o_valid_next;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    o_kind  <= o_kind_next;
    o_value <= o_value_next;
    o_pos   <= o_pos_next;
    o_count <= o_count_next;
    o_rej   <= o_rej_next;
    o_pres  <= o_pres_next;
    o_last  <= o_last_next;
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    idx_next     = idx;
    o_valid_next = o_valid && !m_tready;
    o_kind_next  = o_kind;
    o_value_next = o_value;
    o_pos_next   = o_pos;
    o_count_next = o_count;
    o_rej_next   = o_rej;
    o_pres_next  = o_pres;
    o_last_next  = o_last;

    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          case (cmd)
            CMD_INSERT: begin
              o_valid_next = 1'b1;
              o_kind_next  = KIND_INSERT;
              o_value_next = s_tdata;
              o_pres_next  = 1'b1;
              o_last_next  = 1'b1;
              if (full) begin
                // table full: drop the value, report the unchanged count
                o_pos_next   = '0;
                o_count_next = count;
                o_rej_next   = 1'b1;
              end else begin
                o_pos_next   = ins_pos;
                o_count_next = count + 1'b1;
                o_rej_next   = 1'b0;
                count_next   = count + 1'b1;
              end
            end
            CMD_DUMP: begin
              if (count == '0) begin
                // empty table: one marker result
                o_valid_next = 1'b1;
                o_kind_next  = KIND_DUMP;
                o_value_next = '0;
                o_pos_next   = '0;
                o_count_next = '0;
                o_rej_next   = 1'b0;
                o_pres_next  = 1'b0;
                o_last_next  = 1'b1;
              end else begin
                idx_next   = '0;
                state_next = ST_DUMP;
              end
            end
            CMD_CLEAR: begin
              count_next   = '0;
              o_valid_next = 1'b1;
              o_kind_next  = KIND_CLEAR;
              o_value_next = '0;
              o_pos_next   = '0;
              o_count_next = '0;
              o_rej_next   = 1'b0;
              o_pres_next  = 1'b1;
              o_last_next  = 1'b1;
            end
            default: begin
              // unused command: taken, no result
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          // head cell goes out while the chain rotates one step
          o_valid_next = 1'b1;
          o_kind_next  = KIND_DUMP;
          o_value_next = FIELD_W'(cell_value[0]);
          o_pos_next   = idx;
          o_count_next = count;
          o_rej_next   = 1'b0;
          o_pres_next  = 1'b1;
          o_last_next  = (CNT_W'(idx) + 1'b1 == count);
          idx_next     = idx + 1'b1;
          if (CNT_W'(idx) + 1'b1 == count) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign m_tvalid = o_valid;
  assign m_tuser  = o_kind;
  assign m_tlast  = o_last;
  assign m_tdata  = OUT_BW'({o_pres, o_rej, o_count, o_pos, o_value});

`ifndef SYNTHESIS
  // the count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // a dump burst only runs over a non-empty table
  a_dump_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) |-> (count != '0))
    else $error("dump in progress with empty table");

  // an accepted insert on a non-full table grows the count by one
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |=> (count == $past(count) + 1'b1))
    else $error("insert did not grow the count");

  // a rejected insert reports a full table
  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_rej) |-> (o_kind == KIND_INSERT && o_count == CNT_W'(TABLE_DEPTH)))
    else $error("reject flag without a full table");

  // the chain only rotates while no transaction can be accepted
  a_rot_no_accept: assert property (@(posedge clk) disable iff (rst)
    ctrl.rot |-> !in_accept)
    else $error("input accepted during dump");
`endif

endmodule

/* rtl/sit_cell.sv */
// sit_cell: one storage cell of the sorted chain
// holds one value, compares it to the new value, takes from its neighbors
// depends on sit_pkg
module sit_cell #(
  parameter int VALUE_WIDTH = sit_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  sit_pkg::cell_ctrl_t    ctrl,
  input  logic                   valid,
  input  logic                   is_tail,
  input  logic [VALUE_WIDTH-1:0] ins_value,
  input  logic                   left_gt,
  input  logic [VALUE_WIDTH-1:0] left_value,
  input  logic [VALUE_WIDTH-1:0] right_value,
  input  logic [VALUE_WIDTH-1:0] head_value,
  output logic                   gt,
  output logic [VALUE_WIDTH-1:0] value
);
  import sit_pkg::*;

  // empty cells count as greater so the insert lands at the first free cell
  assign gt = !valid || ($signed(value) > $signed(ins_value));

  always_ff @(posedge clk) begin
    if (ctrl.ins && gt) begin
      value <= left_gt ? left_value : ins_value;
    end else if (ctrl.rot) begin
      value <= is_tail ? head_value : right_value;
    end
  end

endmodule
